/* rtl/lzw_pkg.sv */
// shared types and constants of the lzw compressor
package lzw_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_CODE_W = 12;
  localparam int unsigned MAXC_W     = 12;
  localparam int unsigned FREE_W     = 13;
  localparam int unsigned HASH_MUL   = 31;
  localparam int unsigned HASH_BITS  = 16;
  localparam int unsigned FIRST_FREE = 256;
  localparam logic [MAXC_W-1:0] MAX_CODE_RESET = 12'd4095;

  typedef struct packed {
    logic load_first;
    logic lookup;
    logic probe_next;
    logic take_hit;
    logic mark_miss;
    logic emit_miss;
    logic emit_last;
    logic clear_start;
    logic clear_step;
  } lzw_cmd_t;

  typedef struct packed {
    logic have_prefix;
    logic slot_valid;
    logic key_match;
    logic probe_end;
    logic out_free;
    logic clear_end;
  } lzw_stat_t;

endpackage

/* rtl/lzw_ctrl.sv */
// controller state machine of the lzw compressor
module lzw_ctrl import lzw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      in_last,
  input  lzw_stat_t stat,
  output logic      in_ready,
  output lzw_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;

  logic [2:0] state, state_next;
  logic       last_flag, last_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      last_flag <= 1'b0;
    end else begin
      state     <= state_next;
      last_flag <= last_flag_next;
    end
  end

  always_comb begin
    state_next     = state;
    last_flag_next = last_flag;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          last_flag_next = in_last;
          if (!stat.have_prefix) begin
            cmd.load_first = 1'b1;
            state_next = in_last ? ST_LAST : ST_IDLE;
          end else begin
            cmd.lookup = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        if (stat.slot_valid && stat.key_match) begin
          cmd.take_hit = 1'b1;
          state_next = last_flag ? ST_LAST : ST_IDLE;
        end else if (stat.slot_valid && !stat.probe_end) begin
          cmd.probe_next = 1'b1;
          state_next = ST_READ;
        end else begin
          cmd.mark_miss = 1'b1;
          state_next = ST_MISS;
        end
      end
      ST_MISS: begin
        if (stat.out_free) begin
          cmd.emit_miss = 1'b1;
          state_next = last_flag ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (stat.out_free) begin
          cmd.emit_last   = 1'b1;
          cmd.clear_start = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

/* rtl/lzw_dpath.sv */
// datapath of the lzw compressor: dictionary memory, prefix and output register
module lzw_dpath import lzw_pkg::*; #(
  parameter int CODE_BITS   = 12,
  parameter int TABLE_SLOTS = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_fire,
  input  logic               cfg_we,
  input  logic [MAXC_W-1:0]  cfg_wdata,
  input  lzw_cmd_t           cmd,
  output lzw_stat_t          stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [OUT_CODE_W-1:0] out_code,
  output logic               out_last
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = CODE_BITS + BYTE_W;
  localparam int WORD_W = 1 + KEY_W + CODE_BITS;

  logic [WORD_W-1:0]    mem [TABLE_SLOTS];
  logic [WORD_W-1:0]    rd_word;
  logic [IDX_W-1:0]     addr;
  logic [IDX_W-1:0]     probe_cnt;
  logic [IDX_W-1:0]     clr_addr;
  logic [MAXC_W-1:0]    max_code;
  logic [CODE_BITS-1:0] prefix;
  logic                 have_prefix;
  logic [FREE_W-1:0]    next_free;
  logic [BYTE_W-1:0]    cur_byte;
  logic                 can_insert;
  logic [31:0]          hash_sum;
  logic [IDX_W-1:0]     hash_idx;
  logic [KEY_W-1:0]     cur_key;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  assign hash_sum = 32'(prefix) * 32'(HASH_MUL) + 32'(in_byte);
  assign hash_idx = IDX_W'(32'(hash_sum[HASH_BITS-1:0]) % TABLE_SLOTS);
  assign cur_key  = {prefix, cur_byte};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = {1'b1, cur_key, CODE_BITS'(next_free)};
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (cmd.emit_miss && can_insert) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_word <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_code    <= MAX_CODE_RESET;
      have_prefix <= 1'b0;
      next_free   <= FREE_W'(FIRST_FREE);
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      prefix      <= '0;
    end else begin
      if (cfg_we) max_code <= cfg_wdata;
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.clear_start) begin
        have_prefix <= 1'b0;
        next_free   <= FREE_W'(FIRST_FREE);
        prefix      <= '0;
        clr_addr    <= '0;
      end else begin
        if (cmd.load_first) begin
          prefix      <= CODE_BITS'(in_byte);
          have_prefix <= 1'b1;
        end
        if (cmd.take_hit) prefix <= rd_word[CODE_BITS-1:0];
        if (cmd.emit_miss) begin
          prefix <= CODE_BITS'(cur_byte);
          if (can_insert) next_free <= next_free + 1'b1;
        end
      end
      if (cmd.emit_miss || cmd.emit_last) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) cur_byte <= in_byte;
    if (cmd.lookup) begin
      addr      <= hash_idx;
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      addr      <= (32'(addr) == TABLE_SLOTS - 1) ? '0 : addr + 1'b1;
      probe_cnt <= probe_cnt + 1'b1;
    end
    if (cmd.mark_miss)
      can_insert <= !rd_word[WORD_W-1] && (next_free <= {1'b0, max_code});
    if (cmd.emit_miss || cmd.emit_last) begin
      out_code <= OUT_CODE_W'(prefix);
      out_last <= cmd.emit_last;
    end
  end

  assign stat.have_prefix = have_prefix;
  assign stat.slot_valid  = rd_word[WORD_W-1];
  assign stat.key_match   = rd_word[WORD_W-2 -: KEY_W] == cur_key;
  assign stat.probe_end   = 32'(probe_cnt) == TABLE_SLOTS - 1;
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.clear_end   = 32'(clr_addr) == TABLE_SLOTS - 1;

endmodule

/* rtl/lzw_hashed_compressor.sv */
// top level of the lzw compressor with a hashed dictionary
// a byte that only sets the prefix is taken in the idle state; a lookup passes the read and compare states,
// and each extra probe of the linear probe loop passes both again, as the dictionary memory read is registered
// a miss passes the miss state to load the output register, a last byte the last state as well
// after reset and after each last byte a clearing pass over all TABLE_SLOTS slots runs, no input taken
// rst is synchronous and active high; it restores max_code 4095 and starts the clearing pass
module lzw_hashed_compressor import lzw_pkg::*; #(
  parameter int CODE_BITS   = 12,
  parameter int TABLE_SLOTS = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // code [11:0], zeros above
  output logic        m_tlast,   // last_code
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata  // max_code
);

  lzw_cmd_t  cmd;
  lzw_stat_t stat;
  logic      in_fire;
  logic [OUT_CODE_W-1:0] code;

  assign in_fire = s_tvalid && s_tready;

  lzw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_last  (s_tlast),
    .stat     (stat),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  lzw_dpath #(
    .CODE_BITS   (CODE_BITS),
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_tdata),
    .in_fire   (in_fire),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_code  (code),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0, code};

endmodule

/* test/tb.sv */
// self-checking testbench of the lzw compressor with a hashed dictionary
module tb;
  import lzw_pkg::*;

  localparam int SLOTS = 8192;
  localparam int CLEAR_WAIT = SLOTS + 200;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       eos;
  } byte_item_t;

  typedef struct packed {
    logic [11:0] code;
    logic        last;
  } code_item_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 0;
  logic [11:0] cfg_wdata = '0;

  lzw_hashed_compressor uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [19:0] dict_key [SLOTS];
  logic [11:0] dict_code [SLOTS];
  bit          dict_valid [SLOTS];
  logic [11:0] cur_prefix;
  bit          prefix_set;
  int unsigned free_code;
  int unsigned limit_code;

  byte_item_t pending_bytes[$];
  code_item_t expected_codes[$];

  int errors = 0;
  int bytes_sent = 0;
  int codes_seen = 0;
  int streams_sent = 0;
  bit idle_en = 1;
  int src_gap = 0;
  int sink_gap = 0;
  int hold_cycles = 0;
  bit src_pause = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_dict();
    for (int i = 0; i < SLOTS; i++) dict_valid[i] = 0;
    cur_prefix = '0;
    prefix_set = 0;
    free_code = FIRST_FREE;
  endfunction

  function automatic void compress_byte(byte_item_t it);
    int unsigned idx;
    int unsigned pos;
    bit hit;
    logic [19:0] key;
    hit = 0;
    pos = SLOTS;
    if (!prefix_set) begin
      cur_prefix = 12'(it.data_byte);
      prefix_set = 1;
    end else begin
      key = {cur_prefix, it.data_byte};
      idx = ((cur_prefix * HASH_MUL + it.data_byte) % 65536) % SLOTS;
      for (int n = 0; n < SLOTS; n++) begin
        if (!dict_valid[idx]) begin
          pos = idx;
          break;
        end
        if (dict_key[idx] == key) begin
          pos = idx;
          hit = 1;
          break;
        end
        idx = (idx + 1) % SLOTS;
      end
      if (hit) begin
        cur_prefix = dict_code[pos];
      end else begin
        expected_codes.push_back('{code: cur_prefix, last: 1'b0});
        if (free_code <= limit_code && pos < SLOTS) begin
          dict_key[pos] = key;
          dict_code[pos] = free_code[11:0];
          dict_valid[pos] = 1;
          free_code++;
        end
        cur_prefix = 12'(it.data_byte);
      end
    end
    if (it.eos) begin
      expected_codes.push_back('{code: cur_prefix, last: 1'b1});
      clear_dict();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        compress_byte('{data_byte: s_tdata, eos: s_tlast});
        bytes_sent++;
        if (s_tlast) streams_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 0;
        end else if (!src_pause && pending_bytes.size() > 0 &&
                     !(idle_en && $urandom_range(0, 15) == 0)) begin
          s_tvalid <= 1;
          s_tdata <= pending_bytes[0].data_byte;
          s_tlast <= pending_bytes[0].eos;
          void'(pending_bytes.pop_front());
        end else begin
          s_tvalid <= 0;
          if (idle_en && $urandom_range(0, 3) == 0) src_gap <= $urandom_range(1, 18);
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer code %0d last %0b", $time, m_tdata[11:0], m_tlast);
        end else begin
          if (m_tdata !== {4'b0, expected_codes[0].code}) begin
            errors++;
            $display("%0t: code expected %0d actual %0d", $time,
                     expected_codes[0].code, m_tdata);
          end
          if (m_tlast !== expected_codes[0].last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time,
                     expected_codes[0].last, m_tlast);
          end
          void'(expected_codes.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_tready <= 0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if (idle_en && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 18);
      end
    end
  end

  task automatic add_stream(int len, int alpha);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1));
      it.eos = (i == len - 1);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() > 0 || s_tvalid || expected_codes.size() > 0)
      @(negedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic write_max_code(logic [11:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    limit_code = v;
  endtask

  initial begin
    byte_item_t it;
    limit_code = 4095;
    clear_dict();
    repeat (3) @(posedge clk);
    rst <= 0;
    repeat (CLEAR_WAIT) @(posedge clk);

    // directed: single-byte streams at the extremes, repeats that hit the dictionary
    pending_bytes.push_back('{data_byte: 8'h00, eos: 1'b1});
    pending_bytes.push_back('{data_byte: 8'hff, eos: 1'b1});
    for (int i = 0; i < 12; i++)
      pending_bytes.push_back('{data_byte: (i % 2) ? 8'hff : 8'h00, eos: 1'b0});
    for (int i = 0; i < 8; i++)
      pending_bytes.push_back('{data_byte: 8'h41, eos: (i == 7)});
    wait_drained();

    // smallest dictionary: nothing is ever entered
    write_max_code(12'd0);
    add_stream(20, 2);
    wait_drained();
    write_max_code(12'd256);
    add_stream(30, 3);
    wait_drained();
    write_max_code(12'd270);
    add_stream(60, 4);

    // long receiver hold-off while the sender keeps offering bytes
    @(posedge clk);
    hold_cycles <= 400;
    wait_drained();

    write_max_code(12'd4095);
    while (bytes_sent + pending_bytes.size() < 700) begin
      case ($urandom_range(0, 3))
        0: add_stream($urandom_range(1, 4), 256);
        1: add_stream($urandom_range(20, 80), 4);
        2: add_stream($urandom_range(20, 80), 256);
        default: add_stream($urandom_range(10, 60), 2);
      endcase
      // sender pause until every code is back
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        src_pause = 0;
      end
    end
    wait_drained();

    write_max_code(12'($urandom_range(256, 300)));
    for (int i = 0; i < 4; i++) add_stream($urandom_range(20, 60), 3);
    wait_drained();

    // last part without idling
    idle_en = 0;
    write_max_code(12'd4095);
    for (int i = 0; i < 3; i++) add_stream($urandom_range(40, 80), 256);
    add_stream(1, 256);
    wait_drained();

    $display("sent %0d bytes in %0d streams, checked %0d codes", bytes_sent, streams_sent,
             codes_seen);
    $display("max_code covered 0, 256, small and 4095 settings with stalls on both sides");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
